@@ rtl/core/sfrd_pkg.sv @@
package sfrd_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int STATUS_W = 2;
   localparam logic [BYTE_W-1:0] UNSTUFF_MASK = 8'h20;

   localparam logic [BYTE_W-1:0] FLAG_RESET = 8'h7E;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;
   localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h03;
   localparam logic [BYTE_W-1:0] INFO_EVEN_RESET = 8'h00;
   localparam logic [BYTE_W-1:0] INFO_ODD_RESET = 8'h40;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLAG      = 3'd0,
      CSR_ESCAPE    = 3'd1,
      CSR_ADDRESS   = 3'd2,
      CSR_INFO_EVEN = 3'd3,
      CSR_INFO_ODD  = 3'd4
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_INFO_OK  = 2'd1,
      ST_BAD_FCS  = 2'd2,
      ST_BAD_CTRL = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      PH_HUNT    = 6'b000001,
      PH_FLAG    = 6'b000010,
      PH_ADDR    = 6'b000100,
      PH_CTRL    = 6'b001000,
      PH_HDR_OK  = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag_byte;
      logic [BYTE_W-1:0] escape_byte;
      logic [BYTE_W-1:0] address_byte;
      logic [BYTE_W-1:0] info_control_even;
      logic [BYTE_W-1:0] info_control_odd;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              is_flag;
      logic              is_escape;
      logic              is_address;
   } token_type;

endpackage

@@ rtl/core/serial_frame_receiver_destuff_top.sv @@
// Byte-stuffed frame receiver. Takes one line byte per cycle on req_ unless
// req_stall is high, and returns destuffed payload bytes, one byte behind the
// line, and one end-of-frame report per closed frame on rsp_ (frame_end high,
// control byte in out_byte, status in frame_status). A byte passes a compare
// stage, a two-entry queue and the frame state machine; the sustained rate is
// one byte per cycle while rsp_ is not stalled. A byte from req_ is registered
// in the queue, and the transfer it triggers on rsp_ in the output register.
// Registers on csr_ (flag, escape, address, two info control codes, at indexes
// 0 to 4) are always ready and are to be written only while the block is idle.
module serial_frame_receiver_destuff_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sfrd_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sfrd_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_frame_end,
   output logic [sfrd_pkg::STATUS_W-1:0] rsp_frame_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfrd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfrd_pkg::BYTE_W-1:0]   csr_data
);
   import sfrd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      queue_full;
   logic      push;
   token_type push_token;
   logic      pop;
   logic      head_valid;
   token_type head_token;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FLAG:      cfg_in.flag_byte = csr_data;
            CSR_ESCAPE:    cfg_in.escape_byte = csr_data;
            CSR_ADDRESS:   cfg_in.address_byte = csr_data;
            CSR_INFO_EVEN: cfg_in.info_control_even = csr_data;
            CSR_INFO_ODD:  cfg_in.info_control_odd = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte <= FLAG_RESET;
         cfg_ff.escape_byte <= ESCAPE_RESET;
         cfg_ff.address_byte <= ADDRESS_RESET;
         cfg_ff.info_control_even <= INFO_EVEN_RESET;
         cfg_ff.info_control_odd <= INFO_ODD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfrd_front u_front (
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_token  (push_token)
   );

   sfrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_token (head_token)
   );

   sfrd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head_token       (head_token),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule

@@ rtl/core/sfrd_front.sv @@
module sfrd_front (
   input  sfrd_pkg::cfg_type         cfg,
   input  logic                      req_valid,
   input  logic [sfrd_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                      queue_full,
   output logic                      req_stall,
   output logic                      push,
   output sfrd_pkg::token_type       push_token
);
   import sfrd_pkg::*;

   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;

   always_comb begin
      push_token.data = req_rx_byte;
      push_token.is_flag = (req_rx_byte == cfg.flag_byte);
      push_token.is_escape = (req_rx_byte == cfg.escape_byte);
      push_token.is_address = (req_rx_byte == cfg.address_byte);
   end

endmodule

@@ rtl/core/sfrd_queue.sv @@
module sfrd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfrd_pkg::token_type push_token,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output sfrd_pkg::token_type head_token
);
   import sfrd_pkg::*;

   token_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

@@ rtl/core/sfrd_back.sv @@
module sfrd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sfrd_pkg::cfg_type           cfg,
   input  logic                        head_valid,
   input  sfrd_pkg::token_type         head_token,
   output logic                        pop,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [sfrd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_frame_end,
   output logic [sfrd_pkg::STATUS_W-1:0] rsp_frame_status
);
   import sfrd_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   header_control_ff, header_control_in;
   logic                escape_pending_ff, escape_pending_in;
   logic [BYTE_W-1:0]   held_byte_ff, held_byte_in;
   logic                held_valid_ff, held_valid_in;
   logic [BYTE_W-1:0]   payload_xor_ff, payload_xor_in;
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                out_end_ff, out_end_in;
   status_type          out_status_ff, out_status_in;
   logic                advance;
   logic                emit;
   logic [BYTE_W-1:0]   emit_byte;
   logic                emit_end;
   status_type          emit_status;
   logic [BYTE_W-1:0]   data;
   logic                clear;

   assign advance = !out_valid_ff || !rsp_stall;
   assign pop = head_valid && advance;

   always_comb begin
      phase_in = phase_ff;
      header_control_in = header_control_ff;
      escape_pending_in = escape_pending_ff;
      held_byte_in = held_byte_ff;
      held_valid_in = held_valid_ff;
      payload_xor_in = payload_xor_ff;
      emit = 1'b0;
      emit_byte = header_control_ff;
      emit_end = 1'b1;
      emit_status = ST_OK;
      clear = 1'b0;
      data = escape_pending_ff ? (head_token.data ^ UNSTUFF_MASK) : head_token.data;
      if (pop) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (head_token.is_flag) begin
                  phase_in = PH_FLAG;
               end
            end
            PH_FLAG: begin
               if (head_token.is_address) begin
                  clear = 1'b1;
                  phase_in = PH_ADDR;
               end else if (!head_token.is_flag) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_ADDR: begin
               if (head_token.is_flag) begin
                  phase_in = PH_FLAG;
               end else begin
                  header_control_in = head_token.data;
                  phase_in = PH_CTRL;
               end
            end
            PH_CTRL: begin
               if (head_token.data == (cfg.address_byte ^ header_control_ff)) begin
                  phase_in = PH_HDR_OK;
               end else if (head_token.is_flag) begin
                  phase_in = PH_FLAG;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_HDR_OK: begin
               if (head_token.is_flag) begin
                  clear = 1'b1;
                  phase_in = PH_FLAG;
                  emit = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
                  if (head_token.is_escape) begin
                     escape_pending_in = 1'b1;
                  end else begin
                     held_byte_in = head_token.data;
                     held_valid_in = 1'b1;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (head_token.is_flag) begin
                  if (header_control_ff != cfg.info_control_even &&
                      header_control_ff != cfg.info_control_odd) begin
                     emit_status = ST_BAD_CTRL;
                  end else if (held_valid_ff && held_byte_ff == payload_xor_ff) begin
                     emit_status = ST_INFO_OK;
                  end else begin
                     emit_status = ST_BAD_FCS;
                  end
                  clear = 1'b1;
                  phase_in = PH_FLAG;
                  emit = 1'b1;
               end else if (!escape_pending_ff && head_token.is_escape) begin
                  escape_pending_in = 1'b1;
               end else begin
                  escape_pending_in = 1'b0;
                  held_byte_in = data;
                  held_valid_in = 1'b1;
                  if (held_valid_ff) begin
                     payload_xor_in = payload_xor_ff ^ held_byte_ff;
                     emit = 1'b1;
                     emit_byte = held_byte_ff;
                     emit_end = 1'b0;
                  end
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
         if (clear) begin
            escape_pending_in = 1'b0;
            held_byte_in = '0;
            held_valid_in = 1'b0;
            payload_xor_in = '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in = out_byte_ff;
      out_end_in = out_end_ff;
      out_status_in = out_status_ff;
      if (advance) begin
         out_valid_in = emit;
         if (emit) begin
            out_byte_in = emit_byte;
            out_end_in = emit_end;
            out_status_in = emit_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         header_control_ff <= '0;
         escape_pending_ff <= 1'b0;
         held_byte_ff <= '0;
         held_valid_ff <= 1'b0;
         payload_xor_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         header_control_ff <= header_control_in;
         escape_pending_ff <= escape_pending_in;
         held_byte_ff <= held_byte_in;
         held_valid_ff <= held_valid_in;
         payload_xor_ff <= payload_xor_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_end_ff <= out_end_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_frame_end = out_end_ff;
   assign rsp_frame_status = out_status_ff;

   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_end) |-> (rsp_frame_status == ST_OK))
      else $error("payload byte with nonzero status");
   a_escape_in_payload: assert property (@(posedge clock) disable iff (reset)
      escape_pending_ff |-> (phase_ff == PH_PAYLOAD))
      else $error("escape pending outside payload");
   a_held_in_payload: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (phase_ff == PH_PAYLOAD))
      else $error("held byte outside payload");
   a_close_reopens: assert property (@(posedge clock) disable iff (reset)
      (pop && phase_ff == PH_PAYLOAD && head_token.is_flag)
      |=> (phase_ff == PH_FLAG && !held_valid_ff && out_valid_ff && out_end_ff))
      else $error("closing flag did not report and reopen");

endmodule

@@ verif/sfrd_checker.sv @@
module sfrd_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [sfrd_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [sfrd_pkg::BYTE_W-1:0]        rsp_out_byte,
   input  logic                               rsp_frame_end,
   input  logic [sfrd_pkg::STATUS_W-1:0]      rsp_frame_status,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [sfrd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sfrd_pkg::BYTE_W-1:0]        csr_data,
   output int                                 mismatch_count,
   output int                                 outstanding,
   output int                                 payload_count,
   output int                                 report_count
);
   import sfrd_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              at_end;
      status_type        status;
   } deframed_type;

   cfg_type           cfg;
   phase_type         phase;
   logic [BYTE_W-1:0] ctrl_byte;
   logic [BYTE_W-1:0] held_byte;
   logic [BYTE_W-1:0] payload_xor;
   logic              escape_pending;
   logic              held_valid;
   deframed_type      deframed_q[$];
   int                errors;
   int                payloads;
   int                reports;

   initial begin
      errors = 0;
      payloads = 0;
      reports = 0;
   end

   task automatic clear_payload();
      escape_pending = 1'b0;
      held_byte = '0;
      held_valid = 1'b0;
      payload_xor = '0;
   endtask

   task automatic push_result(input logic [BYTE_W-1:0] data, input logic at_end,
                              input status_type status);
      deframed_type r;
      r.data = data;
      r.at_end = at_end;
      r.status = status;
      deframed_q.push_back(r);
   endtask

   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] d;
      status_type        st;
      case (phase)
         PH_HUNT: begin
            if (b == cfg.flag_byte) phase = PH_FLAG;
         end
         PH_FLAG: begin
            if (b == cfg.address_byte) begin
               clear_payload();
               phase = PH_ADDR;
            end else if (b != cfg.flag_byte) begin
               phase = PH_HUNT;
            end
         end
         PH_ADDR: begin
            if (b == cfg.flag_byte) begin
               phase = PH_FLAG;
            end else begin
               ctrl_byte = b;
               phase = PH_CTRL;
            end
         end
         PH_CTRL: begin
            if (b == (cfg.address_byte ^ ctrl_byte)) phase = PH_HDR_OK;
            else if (b == cfg.flag_byte) phase = PH_FLAG;
            else phase = PH_HUNT;
         end
         PH_HDR_OK: begin
            if (b == cfg.flag_byte) begin
               clear_payload();
               phase = PH_FLAG;
               push_result(ctrl_byte, 1'b1, ST_OK);
            end else begin
               phase = PH_PAYLOAD;
               if (b == cfg.escape_byte) begin
                  escape_pending = 1'b1;
               end else begin
                  held_byte = b;
                  held_valid = 1'b1;
               end
            end
         end
         PH_PAYLOAD: begin
            if (b == cfg.flag_byte) begin
               if (ctrl_byte != cfg.info_control_even && ctrl_byte != cfg.info_control_odd)
                  st = ST_BAD_CTRL;
               else if (held_valid && held_byte == payload_xor)
                  st = ST_INFO_OK;
               else
                  st = ST_BAD_FCS;
               clear_payload();
               phase = PH_FLAG;
               push_result(ctrl_byte, 1'b1, st);
            end else if (escape_pending || b != cfg.escape_byte) begin
               d = escape_pending ? (b ^ UNSTUFF_MASK) : b;
               escape_pending = 1'b0;
               if (held_valid) begin
                  payload_xor = payload_xor ^ held_byte;
                  push_result(held_byte, 1'b0, ST_OK);
               end
               held_byte = d;
               held_valid = 1'b1;
            end else begin
               escape_pending = 1'b1;
            end
         end
         default: phase = PH_HUNT;
      endcase
   endtask

   always @(posedge clock) begin
      deframed_type want;
      if (reset) begin
         cfg = '{FLAG_RESET, ESCAPE_RESET, ADDRESS_RESET, INFO_EVEN_RESET, INFO_ODD_RESET};
         phase = PH_HUNT;
         ctrl_byte = '0;
         clear_payload();
         deframed_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (deframed_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected transfer: byte %h end %b status %0d", $realtime,
                           rsp_out_byte, rsp_frame_end, rsp_frame_status);
            end else begin
               want = deframed_q.pop_front();
               if (rsp_out_byte !== want.data || rsp_frame_end !== want.at_end ||
                   rsp_frame_status !== want.status) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch: expected byte %h end %b status %0d, got %h %b %0d",
                              $realtime, want.data, want.at_end, want.status,
                              rsp_out_byte, rsp_frame_end, rsp_frame_status);
               end
               if (want.at_end) reports++;
               else payloads++;
            end
         end
         if (req_valid && !req_stall) deframe_byte(req_rx_byte);
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FLAG:      cfg.flag_byte = csr_data;
               CSR_ESCAPE:    cfg.escape_byte = csr_data;
               CSR_ADDRESS:   cfg.address_byte = csr_data;
               CSR_INFO_EVEN: cfg.info_control_even = csr_data;
               CSR_INFO_ODD:  cfg.info_control_odd = csr_data;
               default: ;
            endcase
         end
      end
      mismatch_count <= errors;
      outstanding <= deframed_q.size();
      payload_count <= payloads;
      report_count <= reports;
   end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
   import sfrd_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_frame_end;
   logic [STATUS_W-1:0]    rsp_frame_status;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_FLAG;
   logic [BYTE_W-1:0]      csr_data = '0;

   int                     mismatch_count;
   int                     outstanding;
   int                     payload_count;
   int                     report_count;

   int                     gap_pct = 0;
   int                     stall_pct = 0;
   int                     bytes_sent = 0;
   int                     settings_used = 1;
   logic                   last_flag = 1'b0;
   cfg_type                line_cfg;
   logic [BYTE_W-1:0]      line_q[$];

   serial_frame_receiver_destuff_top dut (.*);
   sfrd_checker u_checker (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      #3000000;
      $display("FAILURE");
      $finish;
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin gap_pct = 46; stall_pct = 0;  end
         IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 46; end
         default:       begin gap_pct = 14; stall_pct = 14; end
      endcase
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_line();
      logic [BYTE_W-1:0] b;
      while (line_q.size() > 0) begin
         b = line_q.pop_front();
         send_byte(b);
         last_flag = (b == line_cfg.flag_byte);
         bytes_sent++;
         if (bytes_sent % 40 == 0) set_idling(idle_mode_type'($urandom_range(3)));
      end
   endtask

   // hold off until every transfer has come back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [BYTE_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      csr_put(CSR_FLAG, c.flag_byte);
      csr_put(CSR_ESCAPE, c.escape_byte);
      csr_put(CSR_ADDRESS, c.address_byte);
      csr_put(CSR_INFO_EVEN, c.info_control_even);
      csr_put(CSR_INFO_ODD, c.info_control_odd);
      csr_valid <= 1'b0;
      line_cfg = c;
      settings_used++;
   endtask

   function automatic logic [BYTE_W-1:0] pick_data();
      case ($urandom_range(9))
         0: return line_cfg.flag_byte;
         1: return line_cfg.escape_byte;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic stuff_byte(input logic [BYTE_W-1:0] d);
      if (d == line_cfg.flag_byte || d == line_cfg.escape_byte) begin
         line_q.push_back(line_cfg.escape_byte);
         line_q.push_back(d ^ UNSTUFF_MASK);
      end else begin
         line_q.push_back(d);
      end
   endtask

   task automatic compose_frame();
      int                kind;
      int                len;
      int                sel;
      logic [BYTE_W-1:0] ctrl;
      logic [BYTE_W-1:0] chk;
      logic [BYTE_W-1:0] d;
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 6)) line_q.push_back(pick_data());
      end else begin
         if (!last_flag || $urandom_range(4) == 0) line_q.push_back(line_cfg.flag_byte);
         if ($urandom_range(9) == 0) line_q.push_back(line_cfg.flag_byte);
         line_q.push_back(($urandom_range(19) == 0) ? pick_data() : line_cfg.address_byte);
         sel = $urandom_range(9);
         if (sel < 4) ctrl = line_cfg.info_control_even;
         else if (sel < 8) ctrl = line_cfg.info_control_odd;
         else ctrl = pick_data();
         line_q.push_back(ctrl);
         line_q.push_back(($urandom_range(14) == 0) ? pick_data()
                                                    : line_cfg.address_byte ^ ctrl);
         if (kind < 25) begin
            line_q.push_back(line_cfg.flag_byte);
         end else begin
            len = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(6);
            chk = '0;
            repeat (len) begin
               d = pick_data();
               chk ^= d;
               stuff_byte(d);
            end
            if ($urandom_range(9) == 0) chk ^= 8'($urandom_range(1, 255));
            sel = $urandom_range(19);
            if (sel == 0) line_q.push_back(line_cfg.escape_byte);
            else if (sel != 1) stuff_byte(chk);
            if ($urandom_range(19) != 0) line_q.push_back(line_cfg.flag_byte);
         end
      end
   endtask

   task automatic run_traffic(input int n);
      int target;
      target = bytes_sent + n;
      set_idling(IDLE_NONE);
      while (bytes_sent < target) begin
         compose_frame();
         send_line();
      end
   endtask

   initial begin
      cfg_type plan[$];
      line_cfg = '{FLAG_RESET, ESCAPE_RESET, ADDRESS_RESET, INFO_EVEN_RESET, INFO_ODD_RESET};
      plan = '{'{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h01},
               '{8'hFF, 8'h00, 8'h00, 8'h7E, 8'h81},
               '{8'h3C, 8'h1C, 8'h3C, 8'h5A, 8'h3C},
               '{8'h55, 8'h55, 8'($urandom), 8'($urandom), 8'($urandom)}};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // repeated flags, flag in place of control, double escape, shared flag,
      // supervisory frame, raw flag after escape, bad control, bad header
      line_q = '{FLAG_RESET, FLAG_RESET, ADDRESS_RESET, FLAG_RESET,
                 ADDRESS_RESET, INFO_EVEN_RESET, ADDRESS_RESET ^ INFO_EVEN_RESET,
                 8'hFF, ESCAPE_RESET, ESCAPE_RESET, 8'h00,
                 8'hFF ^ ESCAPE_RESET ^ UNSTUFF_MASK, FLAG_RESET,
                 ADDRESS_RESET, 8'h81, ADDRESS_RESET ^ 8'h81, FLAG_RESET,
                 ADDRESS_RESET, INFO_ODD_RESET, ADDRESS_RESET ^ INFO_ODD_RESET,
                 ESCAPE_RESET, FLAG_RESET,
                 ADDRESS_RESET, 8'h55, ADDRESS_RESET ^ 8'h55, 8'h11, FLAG_RESET,
                 ADDRESS_RESET, INFO_EVEN_RESET, 8'h98};
      send_line();
      run_traffic(120);

      foreach (plan[i]) begin
         settle();
         load_config(plan[i]);
         last_flag = 1'b0;
         run_traffic(150);
      end
      settle();

      $display("Sent %0d line bytes under %0d register settings with varied idling.",
               bytes_sent, settings_used);
      $display("Checked %0d payload bytes and %0d frame reports.", payload_count, report_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
